FILE: hdl/vshp_pkg.sv
// Shared types and constants for the video sequence header parser.
`default_nettype none

package vshp_pkg;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_INTRA    = 2'd1;
  localparam logic [1:0] KIND_NONINTRA = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  localparam logic [5:0] HDR_LAST_BYTE = 6'd7;
  localparam logic [5:0] ENTRY_LAST    = 6'd63;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] horizontal_size;
    logic [11:0] vertical_size;
    logic [3:0]  aspect_ratio;
    logic [3:0]  frame_rate;
    logic [17:0] bit_rate;
    logic [9:0]  vbv_size;
    logic        constrained;
    logic        intra_follows;
    logic [5:0]  entry_index;
    logic [7:0]  entry_value;
    logic        last;
  } result_t;

  // up to two results per request; push1 only together with push0
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

FILE: hdl/vshp_parse.sv
// Byte-level parse state machine: header capture and matrix entry extraction.
`default_nettype none

module vshp_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic [7:0]     stream_byte,
  input  wire logic           header_start,
  output vshp_pkg::push_t     push
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR, PH_INTRA, PH_NONINTRA, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [5:0]  cnt_r, cnt_nxt, cnt_eff;
  logic        carry_r, carry_nxt;
  logic [55:0] hdr_r, hdr_nxt;
  logic [63:0] word;
  vshp_pkg::result_t hdr_res, end_res, ent_res;

  assign word = {hdr_r, stream_byte};

  always_comb begin
    hdr_res                 = '0;
    hdr_res.kind            = vshp_pkg::KIND_HEADER;
    hdr_res.horizontal_size = word[63:52];
    hdr_res.vertical_size   = word[51:40];
    hdr_res.aspect_ratio    = word[39:36];
    hdr_res.frame_rate      = word[35:32];
    hdr_res.bit_rate        = word[31:14];
    // word[13] is the marker bit, not checked
    hdr_res.vbv_size        = word[12:3];
    hdr_res.constrained     = word[2];
    hdr_res.intra_follows   = word[1];

    end_res      = '0;
    end_res.kind = vshp_pkg::KIND_END;
    end_res.last = 1'b1;

    ent_res             = '0;
    ent_res.entry_index = cnt_eff;
    if (phase_eff == PH_INTRA) begin
      ent_res.kind        = vshp_pkg::KIND_INTRA;
      ent_res.entry_value = {carry_r, stream_byte[7:1]};
    end else begin
      ent_res.kind        = vshp_pkg::KIND_NONINTRA;
      ent_res.entry_value = stream_byte;
      ent_res.last        = (cnt_eff == vshp_pkg::ENTRY_LAST);
    end
  end

  always_comb begin
    phase_eff = header_start ? PH_HDR : phase_r;
    cnt_eff   = header_start ? 6'd0 : cnt_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    carry_nxt = carry_r;
    hdr_nxt   = hdr_r;
    push      = '0;
    if (fire) begin
      phase_nxt = phase_eff;
      cnt_nxt   = cnt_eff;
      case (phase_eff)
        PH_HDR: begin
          if (cnt_eff == vshp_pkg::HDR_LAST_BYTE) begin
            push.push0 = 1'b1;
            push.res0  = hdr_res;
            cnt_nxt    = 6'd0;
            carry_nxt  = stream_byte[0];
            if (word[1]) begin
              phase_nxt = PH_INTRA;
            end else if (stream_byte[0]) begin
              phase_nxt = PH_NONINTRA;
            end else begin
              push.push1 = 1'b1;
              push.res1  = end_res;
              phase_nxt  = PH_DONE;
            end
          end else begin
            hdr_nxt = {hdr_r[47:0], stream_byte};
            cnt_nxt = cnt_eff + 6'd1;
          end
        end
        PH_INTRA: begin
          push.push0 = 1'b1;
          push.res0  = ent_res;
          carry_nxt  = stream_byte[0];
          cnt_nxt    = cnt_eff + 6'd1;
          if (cnt_eff == vshp_pkg::ENTRY_LAST) begin
            if (stream_byte[0]) begin
              phase_nxt = PH_NONINTRA;
            end else begin
              push.push1 = 1'b1;
              push.res1  = end_res;
              phase_nxt  = PH_DONE;
            end
          end
        end
        PH_NONINTRA: begin
          push.push0 = 1'b1;
          push.res0  = ent_res;
          cnt_nxt    = cnt_eff + 6'd1;
          if (cnt_eff == vshp_pkg::ENTRY_LAST) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 6'd0;
      carry_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      carry_r <= carry_nxt;
    end
    hdr_r <= hdr_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/vshp_outq.sv
// Four-entry result queue taking up to two results per cycle.
`default_nettype none

module vshp_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  vshp_pkg::push_t        push,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vshp_pkg::result_t      out_res
);

  vshp_pkg::result_t mem_r [4];
  logic [2:0] count_r, count_nxt;
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [1:0] tail_p1;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[head_r];
  assign space     = (count_r <= 3'd2);
  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + 2'd1;

  always_comb begin
    count_nxt = count_r + {2'b00, push.push0} + {2'b00, push.push1} - {2'b00, pop};
    head_nxt  = head_r + {1'b0, pop};
    tail_nxt  = tail_r + {1'b0, push.push0} + {1'b0, push.push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
      head_r  <= 2'd0;
      tail_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
    for (int i = 0; i < 4; i++) begin
      if (push.push0 && tail_r == 2'(i)) begin
        mem_r[i] <= push.res0;
      end else if (push.push1 && tail_p1 == 2'(i)) begin
        mem_r[i] <= push.res1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/video_sequence_header_parser.sv
// Video sequence header parser: bytes after the start code in, field results out.
//
// Input channel (in_valid/in_ready): one byte of header body per request, bits
// taken MSB first; in_header_start marks the first byte of a header and
// restarts parsing at any point. Bytes while idle or after a header ends are
// dropped without result.
// Result channel (out_valid/out_ready): one header result (kind 0), then one
// result per intra and non-intra matrix entry (kinds 1, 2), or kind 3 when no
// non-intra matrix follows; out_last flags the final result of a header.
// Output: each result is registered in the result queue before it appears at the port.
// Throughput: one byte per cycle while in_ready is high. A byte yields at most
// two results, which go into a four-entry result queue; in_ready is high while
// the queue has room for two, so a byte that yields two results uses two of
// the queue's entries.
// Stall: when out_ready is low the queue fills and in_ready drops; no result
// is lost. Reset (rst_n low, synchronous) empties the queue and returns the
// parser to idle, waiting for a header start.
`default_nettype none

module video_sequence_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_header_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [11:0]      out_horizontal_size,
  output logic [11:0]      out_vertical_size,
  output logic [3:0]       out_aspect_ratio,
  output logic [3:0]       out_frame_rate,
  output logic [17:0]      out_bit_rate,
  output logic [9:0]       out_vbv_size,
  output logic             out_constrained,
  output logic             out_intra_follows,
  output logic [5:0]       out_entry_index,
  output logic [7:0]       out_entry_value,
  output logic             out_last
);

  vshp_pkg::push_t   push;
  vshp_pkg::result_t res;
  logic              fire;

  assign fire = in_valid && in_ready;

  vshp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .stream_byte  (in_stream_byte),
    .header_start (in_header_start),
    .push         (push)
  );

  vshp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind            = res.kind;
  assign out_horizontal_size = res.horizontal_size;
  assign out_vertical_size   = res.vertical_size;
  assign out_aspect_ratio    = res.aspect_ratio;
  assign out_frame_rate      = res.frame_rate;
  assign out_bit_rate        = res.bit_rate;
  assign out_vbv_size        = res.vbv_size;
  assign out_constrained     = res.constrained;
  assign out_intra_follows   = res.intra_follows;
  assign out_entry_index     = res.entry_index;
  assign out_entry_value     = res.entry_value;
  assign out_last            = res.last;

endmodule

`default_nettype wire

FILE: hdl/vshp_checker.sv
// Port-level assertions for the video sequence header parser, bound to the top.
`default_nettype none

module vshp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [11:0] out_horizontal_size,
  input wire logic        out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      (out_kind == vshp_pkg::KIND_NONINTRA || out_kind == vshp_pkg::KIND_END))
    else $error("last flag on a header or intra result");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != vshp_pkg::KIND_HEADER |-> out_horizontal_size == 12'd0)
    else $error("header field set on a non-header result");

endmodule

bind video_sequence_header_parser vshp_checker u_vshp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_kind            (out_kind),
  .out_horizontal_size (out_horizontal_size),
  .out_last            (out_last)
);

`default_nettype wire

FILE: tb/video_sequence_header_parser_tb.sv
// Self-checking testbench for the video sequence header parser: random and directed headers.
`default_nettype none

module video_sequence_header_parser_tb;

  localparam int ITEMS       = 1650;
  localparam int MARKER_POS  = 50;
  localparam int HEADER_BITS = 63;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_INTRA, PH_NFLAG, PH_NONINTRA, PH_DONE
  } parse_phase_t;

  class header_tracker;
    vshp_pkg::result_t results_due[$];
    parse_phase_t pstate;
    logic [61:0]  hdr_bits;
    int unsigned  hdr_taken;
    logic [7:0]   entry_bits;
    logic [3:0]   entry_nbits;
    logic [5:0]   entry_idx;
    int errors, accepted, ignored, headers, intra_seen, nonintra_seen, closes;

    function new();
      clear();
    endfunction

    function void clear();
      pstate      = PH_IDLE;
      hdr_bits    = '0;
      hdr_taken   = 0;
      entry_bits  = '0;
      entry_nbits = '0;
      entry_idx   = '0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void push(logic [1:0] k, logic [5:0] idx, logic [7:0] v, logic l);
      vshp_pkg::result_t r;
      r = '0;
      r.kind        = k;
      r.entry_index = idx;
      r.entry_value = v;
      r.last        = l;
      results_due.push_back(r);
    endfunction

    function void take_bit(logic b);
      vshp_pkg::result_t r;
      logic    fin;
      case (pstate)
        PH_HEADER: begin
          if (hdr_taken != MARKER_POS) hdr_bits = {hdr_bits[60:0], b};
          hdr_taken++;
          if (hdr_taken == HEADER_BITS) begin
            r = '0;
            r.kind            = vshp_pkg::KIND_HEADER;
            r.horizontal_size = hdr_bits[61:50];
            r.vertical_size   = hdr_bits[49:38];
            r.aspect_ratio    = hdr_bits[37:34];
            r.frame_rate      = hdr_bits[33:30];
            r.bit_rate        = hdr_bits[29:12];
            r.vbv_size        = hdr_bits[11:2];
            r.constrained     = hdr_bits[1];
            r.intra_follows   = hdr_bits[0];
            results_due.push_back(r);
            entry_bits  = '0;
            entry_nbits = '0;
            entry_idx   = '0;
            pstate = hdr_bits[0] ? PH_INTRA : PH_NFLAG;
          end
        end
        PH_INTRA, PH_NONINTRA: begin
          entry_bits = {entry_bits[6:0], b};
          entry_nbits++;
          if (entry_nbits == 4'd8) begin
            fin = (entry_idx == vshp_pkg::ENTRY_LAST);
            if (pstate == PH_INTRA) begin
              push(vshp_pkg::KIND_INTRA, entry_idx, entry_bits, 1'b0);
              if (fin) pstate = PH_NFLAG;
            end else begin
              push(vshp_pkg::KIND_NONINTRA, entry_idx, entry_bits, fin);
              if (fin) pstate = PH_DONE;
            end
            entry_idx++;
            entry_nbits = '0;
            entry_bits  = '0;
          end
        end
        PH_NFLAG: begin
          if (b) begin
            entry_idx   = '0;
            entry_nbits = '0;
            entry_bits  = '0;
            pstate      = PH_NONINTRA;
          end else begin
            push(vshp_pkg::KIND_END, 6'd0, 8'd0, 1'b1);
            pstate = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] b, logic s);
      accepted++;
      if (s) begin
        clear();
        pstate = PH_HEADER;
      end else if (pstate == PH_IDLE || pstate == PH_DONE) begin
        ignored++;
      end
      for (int i = 7; i >= 0; i--) take_bit(b[i]);
    endfunction

    function string show(vshp_pkg::result_t r);
      return {$sformatf("kind=%0d h=%0d v=%0d ar=%0d fr=%0d br=%0d ",
                        r.kind, r.horizontal_size, r.vertical_size, r.aspect_ratio,
                        r.frame_rate, r.bit_rate),
              $sformatf("vbv=%0d c=%0b i=%0b idx=%0d val=%0d last=%0b",
                        r.vbv_size, r.constrained, r.intra_follows, r.entry_index,
                        r.entry_value, r.last)};
    endfunction

    function void check_result(vshp_pkg::result_t got);
      vshp_pkg::result_t want;
      logic    bad;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = results_due.pop_front();
      bad = (got.kind !== want.kind) ||
            (got.horizontal_size !== want.horizontal_size) ||
            (got.vertical_size !== want.vertical_size) ||
            (got.aspect_ratio !== want.aspect_ratio) ||
            (got.frame_rate !== want.frame_rate) ||
            (got.bit_rate !== want.bit_rate) ||
            (got.vbv_size !== want.vbv_size) ||
            (got.constrained !== want.constrained) ||
            (got.intra_follows !== want.intra_follows) ||
            (got.entry_index !== want.entry_index) ||
            (got.entry_value !== want.entry_value) ||
            (got.last !== want.last);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
      case (want.kind)
        vshp_pkg::KIND_HEADER:   headers++;
        vshp_pkg::KIND_INTRA:    intra_seen++;
        vshp_pkg::KIND_NONINTRA: nonintra_seen++;
        default:                 closes++;
      endcase
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_stream_byte;
  logic        in_header_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [11:0] out_horizontal_size;
  logic [11:0] out_vertical_size;
  logic [3:0]  out_aspect_ratio;
  logic [3:0]  out_frame_rate;
  logic [17:0] out_bit_rate;
  logic [9:0]  out_vbv_size;
  logic        out_constrained;
  logic        out_intra_follows;
  logic [5:0]  out_entry_index;
  logic [7:0]  out_entry_value;
  logic        out_last;
  vshp_pkg::result_t seen;
  bit          calm;

  header_tracker trk = new();

  video_sequence_header_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_stream_byte      (in_stream_byte),
    .in_header_start     (in_header_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_horizontal_size (out_horizontal_size),
    .out_vertical_size   (out_vertical_size),
    .out_aspect_ratio    (out_aspect_ratio),
    .out_frame_rate      (out_frame_rate),
    .out_bit_rate        (out_bit_rate),
    .out_vbv_size        (out_vbv_size),
    .out_constrained     (out_constrained),
    .out_intra_follows   (out_intra_follows),
    .out_entry_index     (out_entry_index),
    .out_entry_value     (out_entry_value),
    .out_last            (out_last)
  );

  assign seen = {out_kind, out_horizontal_size, out_vertical_size, out_aspect_ratio,
                 out_frame_rate, out_bit_rate, out_vbv_size, out_constrained,
                 out_intra_follows, out_entry_index, out_entry_value, out_last};

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) trk.check_result(seen);
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [31:0] pick(int w);
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return (32'd1 << w) - 1;
      default: return $urandom & ((32'd1 << w) - 1);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_stream_byte  <= b;
    in_header_start <= s;
    do @(posedge clk); while (!in_ready);
    trk.note_request(b, s);
  endtask

  // header body bits MSB first: fields, random marker, optional matrices, padding
  task automatic send_header(input logic [61:0] f, input logic nonintra, input int cut);
    bit         bits[$];
    logic [7:0] b;
    int         nb;
    for (int i = 61; i >= 12; i--) bits.push_back(f[i]);
    bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 11; i >= 0; i--) bits.push_back(f[i]);
    if (f[0]) repeat (512) bits.push_back(1'($urandom_range(0, 1)));
    bits.push_back(nonintra);
    if (nonintra) repeat (512) bits.push_back(1'($urandom_range(0, 1)));
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(0, 1)));
    nb = bits.size() / 8;
    if (cut > 0 && cut < nb) nb = cut;
    for (int k = 0; k < nb; k++) begin
      for (int j = 0; j < 8; j++) b[7-j] = bits[8*k+j];
      send_byte(b, k == 0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (trk.pending() != 0);
  endtask

  initial begin
    logic [11:0] hs, vs;
    logic [3:0]  ar, fr;
    logic [17:0] br;
    logic [9:0]  vbv;
    logic        con, intra, non;
    int          r, cut, nseq;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_stream_byte  <= 8'd0;
    in_header_start <= 1'b0;
    calm = 1'b0;
    nseq = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hA5, 1'b0);
    send_header({{61{1'b1}}, 1'b0}, 1'b0, 0);
    send_byte(8'hFF, 1'b0);
    send_header(62'd0, 1'b0, 0);
    send_header({{61{1'b1}}, 1'b0}, 1'b0, 2);
    send_header({12'd1920, 12'd1080, 4'd3, 4'd4, 18'd15000, 10'd112, 1'b0, 1'b0}, 1'b0, 0);
    drain();

    while (trk.accepted - trk.ignored < ITEMS) begin
      nseq++;
      if ($urandom_range(0, 3) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        hs  = 12'(pick(12));
        vs  = 12'(pick(12));
        ar  = 4'(pick(4));
        fr  = 4'(pick(4));
        br  = 18'(pick(18));
        vbv = 10'(pick(10));
        con = 1'($urandom_range(0, 1));
        intra = (r >= 64 && r < 78) || r >= 92;
        non   = r >= 78;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 0;
        send_header({hs, vs, ar, fr, br, vbv, con, intra}, non, cut);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
      end
      if (nseq % 12 == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d bytes sent (%0d dropped while idle), %0d headers parsed",
             trk.accepted, trk.ignored, trk.headers);
    $display("%0d intra and %0d non-intra entries, %0d end-of-header results, %0d errors",
             trk.intra_seen, trk.nonintra_seen, trk.closes, trk.errors);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
